>>> hw/rtl/ptd_pkg.sv
// Shared types, constants and helpers for the priority task dispatcher.
`default_nettype none

package ptd_pkg;

    // Task count and derived widths
    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int TASK_W    = 4;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    typedef logic [NUM_TASKS-1:0] t_mask;
    typedef logic [IDX_W-1:0]     t_idx;

    // Operation codes; code 3 is unused
    typedef enum logic [OP_W-1:0] {
        OP_QUEUE   = 2'd0,
        OP_QUERY   = 2'd1,
        OP_ADVANCE = 2'd2
    } t_opcode;

    // Task status codes reported by a query
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 2'd0,
        ST_QUEUED  = 2'd1,
        ST_PENDING = 2'd2,
        ST_RUNNING = 2'd3
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming transaction
        logic exec;   // run a queue, query or unused operation
        logic merge;  // advance step one: retire running task, merge queue
        logic pick;   // advance step two: dispatch lowest pending task
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_advance;
    } t_dp_status;

    // Index of the lowest set bit; zero when the mask is empty
    function automatic t_idx lowest_idx(input t_mask m);
        t_idx res;
        res = '0;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if (m[i]) begin
                res = IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ptd_ctrl.sv
// Controller state machine of the priority task dispatcher.
`default_nettype none

module ptd_ctrl
    import ptd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_dp_status,
    output t_dp_cmd         o_dp_cmd,
    output logic            o_busy,
    output logic            o_result_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_PICK
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_strobe, n_strobe;

    // Decode next state and commands
    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = S_DECODE;
                    n_busy        = 1'b1;
                end
            end
            S_DECODE: begin
                if (i_dp_status.is_advance) begin
                    o_dp_cmd.merge = 1'b1;
                    n_state        = S_PICK;
                end else begin
                    o_dp_cmd.exec = 1'b1;
                    n_strobe      = 1'b1;
                    n_state       = S_IDLE;
                    n_busy        = 1'b0;
                end
            end
            S_PICK: begin
                o_dp_cmd.pick = 1'b1;
                n_strobe      = 1'b1;
                n_state       = S_IDLE;
                n_busy        = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy         = r_busy;
    assign o_result_valid = r_strobe;

endmodule

`default_nettype wire

>>> hw/rtl/ptd_datapath.sv
// Datapath of the priority task dispatcher: task masks, running task, results.
`default_nettype none

module ptd_datapath
    import ptd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_dp_cmd,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [TASK_W-1:0] i_task_index,
    output t_dp_status             o_dp_status,
    output logic [STATUS_W-1:0]    o_task_status,
    output logic                   o_dispatch_valid,
    output logic [TASK_W-1:0]      o_dispatched_task,
    output logic                   o_idle_run
);

    // Captured transaction
    logic [OP_W-1:0]   r_op;
    logic [TASK_W-1:0] r_task;

    // Scheduler state
    t_mask r_queued, r_pending;
    logic  r_run_valid;
    t_idx  r_run_idx;

    // Result registers
    logic [STATUS_W-1:0] r_status;
    logic                r_disp_valid;
    logic [TASK_W-1:0]   r_disp_task;
    logic                r_idle_run;

    logic      in_range;
    t_mask     task_bit;
    t_mask     below;
    logic      do_merge;
    t_idx      next_idx;
    t_status   query_status;

    // Decode the captured task
    assign in_range = 32'(r_task) < NUM_TASKS;
    assign task_bit = in_range ? (t_mask'(1) << r_task) : '0;

    // Bits below the lowest pending task; all bits when nothing is pending
    assign below    = (r_pending - t_mask'(1)) & ~r_pending;
    assign do_merge = |(r_queued & below);
    assign next_idx = lowest_idx(r_pending);

    // Status precedence: running, pending, queued, idle
    always_comb begin
        if (r_run_valid && in_range && (32'(r_run_idx) == 32'(r_task))) begin
            query_status = ST_RUNNING;
        end else if (|(r_pending & task_bit)) begin
            query_status = ST_PENDING;
        end else if (|(r_queued & task_bit)) begin
            query_status = ST_QUEUED;
        end else begin
            query_status = ST_IDLE;
        end
    end

    assign o_dp_status.is_advance = (t_opcode'(r_op) == OP_ADVANCE);

    // Capture transaction fields
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_op   <= i_opcode;
            r_task <= i_task_index;
        end
    end

    // Update scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued    <= '0;
            r_pending   <= '0;
            r_run_valid <= 1'b0;
            r_run_idx   <= '0;
        end else if (i_dp_cmd.exec) begin
            if (t_opcode'(r_op) == OP_QUEUE) begin
                r_queued <= r_queued | task_bit;
            end
        end else if (i_dp_cmd.merge) begin
            r_run_valid <= 1'b0;
            if (do_merge) begin
                r_pending <= r_pending | r_queued;
                r_queued  <= '0;
            end
        end else if (i_dp_cmd.pick) begin
            if (|r_pending) begin
                r_pending[next_idx] <= 1'b0;
                r_run_valid         <= 1'b1;
                r_run_idx           <= next_idx;
            end
        end
    end

    // Load result fields
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            r_disp_valid <= 1'b0;
            r_disp_task  <= '0;
            r_idle_run   <= 1'b0;
            case (t_opcode'(r_op))
                OP_QUERY: r_status <= query_status;
                default:  r_status <= ST_IDLE;
            endcase
        end else if (i_dp_cmd.pick) begin
            r_status     <= ST_IDLE;
            r_disp_valid <= |r_pending;
            r_disp_task  <= (|r_pending) ? TASK_W'(next_idx) : '0;
            r_idle_run   <= ~(|r_pending);
        end
    end

    assign o_task_status     = r_status;
    assign o_dispatch_valid  = r_disp_valid;
    assign o_dispatched_task = r_disp_task;
    assign o_idle_run        = r_idle_run;

endmodule

`default_nettype wire

>>> hw/rtl/priority_task_dispatcher.sv
// Top level of the priority task dispatcher.
`default_nettype none

// Fixed-priority task dispatcher, one bit per task, lowest index first.
// A transaction is taken when start is high and busy is low; the block then
// works on it alone. Queue, query and unused operations execute in the decode
// state and their result is registered there. Advance adds the pick state: the
// merge of the queue runs in the decode state and the priority pick in the pick
// state, where its result is registered. A new transaction can be started only
// once busy has fallen, so transactions do not overlap. Each result shows on
// the output ports for one cycle with o_result_valid high; the receiver
// cannot stall it and must take it then. Busy falls in the same cycle as the
// result strobe.
module priority_task_dispatcher
    import ptd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_opcode,
    input  wire logic [TASK_W-1:0]   i_task_index,
    output logic                     o_result_valid,
    output logic [STATUS_W-1:0]      o_task_status,
    output logic                     o_dispatch_valid,
    output logic [TASK_W-1:0]        o_dispatched_task,
    output logic                     o_idle_run
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequence each transaction
    ptd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_dp_status    (dp_status),
        .o_dp_cmd       (dp_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    // Hold masks and compute results
    ptd_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .i_opcode          (i_opcode),
        .i_task_index      (i_task_index),
        .o_dp_status       (dp_status),
        .o_task_status     (o_task_status),
        .o_dispatch_valid  (o_dispatch_valid),
        .o_dispatched_task (o_dispatched_task),
        .o_idle_run        (o_idle_run)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ptd_checker.sv
// Port-level assertions for the priority task dispatcher, with its bind.
`default_nettype none

module ptd_checker
    import ptd_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_result_valid,
    input wire logic [STATUS_W-1:0] o_task_status,
    input wire logic                o_dispatch_valid,
    input wire logic [TASK_W-1:0]   o_dispatched_task,
    input wire logic                o_idle_run
);

    // Accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // Result only ends a busy period
    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside a busy period");

    // Advance either dispatches or reports idle, never both
    a_disp_xor_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_dispatch_valid && o_idle_run))
        else $error("dispatch and idle reported together");

    // No dispatch means task index zero
    a_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_dispatch_valid) |-> (o_dispatched_task == '0))
        else $error("dispatched task nonzero without dispatch");

    // Status only on non-advance results
    a_status_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_task_status != '0)) |-> (!o_dispatch_valid && !o_idle_run))
        else $error("task status on an advance result");

endmodule

bind priority_task_dispatcher ptd_checker u_ptd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_result_valid    (o_result_valid),
    .o_task_status     (o_task_status),
    .o_dispatch_valid  (o_dispatch_valid),
    .o_dispatched_task (o_dispatched_task),
    .o_idle_run        (o_idle_run)
);

`default_nettype wire

>>> verif/priority_task_dispatcher_tb.sv
// Self-checking testbench for the priority task dispatcher.
`timescale 1ns / 1ps

module priority_task_dispatcher_tb
    import ptd_pkg::*;
();

    // Opcode that the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef bit t_bool;

    // One command transaction and the idle chance before it is presented
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] idx;
        int unsigned       gap_pct;
    } t_cmd;

    // One result transaction as the block should report it
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                dispatch_valid;
        logic [TASK_W-1:0]   dispatched;
        logic                idle_run;
    } t_outcome;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OP_W-1:0]     i_opcode = '0;
    logic [TASK_W-1:0]   i_task_index = '0;
    wire                 busy;
    wire                 o_result_valid;
    wire [STATUS_W-1:0]  o_task_status;
    wire                 o_dispatch_valid;
    wire [TASK_W-1:0]    o_dispatched_task;
    wire                 o_idle_run;

    t_cmd        cmd_queue[$];
    t_outcome    expected_outcomes[$];
    logic        took_cmd = 1'b0;
    int unsigned cmds_issued = 0;
    int unsigned cmds_taken = 0;
    int unsigned error_count = 0;

    // Scheduler state mirrored by the predictor
    t_mask             sched_queued;
    t_mask             sched_pending;
    logic [4:0]        sched_scan;
    logic              sched_running;
    logic [TASK_W-1:0] sched_run_idx;

    priority_task_dispatcher uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_task_index      (i_task_index),
        .o_result_valid    (o_result_valid),
        .o_task_status     (o_task_status),
        .o_dispatch_valid  (o_dispatch_valid),
        .o_dispatched_task (o_dispatched_task),
        .o_idle_run        (o_idle_run)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Find the highest-priority set bit; NUM_TASKS when the mask is empty
    function automatic int first_task(input t_mask m);
        int pos;
        pos = NUM_TASKS;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if (m[i]) begin
                pos = i;
            end
        end
        return pos;
    endfunction

    // Apply one transaction to the mirrored state and return its outcome
    task automatic schedule_step(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] idx,
                                 output t_outcome res);
        logic  in_range;
        t_mask sel;
        t_mask below;
        int    low;
        in_range = int'(idx) < NUM_TASKS;
        sel = in_range ? (t_mask'(1) << idx) : '0;
        res.status = ST_IDLE;
        res.dispatch_valid = 1'b0;
        res.dispatched = '0;
        res.idle_run = 1'b0;
        case (op)
            OP_QUEUE: begin
                sched_queued = sched_queued | sel;
            end
            OP_QUERY: begin
                if (sched_running && in_range && sched_run_idx == idx) begin
                    res.status = ST_RUNNING;
                end else if ((sched_pending & sel) != '0) begin
                    res.status = ST_PENDING;
                end else if ((sched_queued & sel) != '0) begin
                    res.status = ST_QUEUED;
                end
            end
            OP_ADVANCE: begin
                sched_running = 1'b0;
                // Tasks queued ahead of the pending ones force a new snapshot
                if (sched_pending != '0) begin
                    below = (t_mask'(1) << first_task(sched_pending)) - t_mask'(1);
                end else begin
                    below = '1;
                end
                if ((sched_queued & below) != '0) begin
                    sched_pending = sched_pending | sched_queued;
                    sched_queued = '0;
                end
                if (sched_pending == '0) begin
                    sched_scan = '0;
                    res.idle_run = 1'b1;
                end else begin
                    low = first_task(sched_pending);
                    sched_pending[low] = 1'b0;
                    sched_running = 1'b1;
                    sched_run_idx = TASK_W'(low);
                    sched_scan = 5'(low + 1);
                    res.dispatch_valid = 1'b1;
                    res.dispatched = TASK_W'(low);
                end
            end
            default: begin
                // Unused opcode: no state change, all fields zero
            end
        endcase
    endtask

    // Driver: present the next transaction at the falling edge
    always @(negedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_cmd) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= cmd_queue[0].gap_pct) begin
                nxt = cmd_queue.pop_front();
                start <= 1'b1;
                i_opcode <= nxt.op;
                i_task_index <= nxt.idx;
                cmds_issued <= cmds_issued + 1;
            end else begin
                // Idle with junk on the payload
                start <= 1'b0;
                i_opcode <= OP_W'($urandom);
                i_task_index <= TASK_W'($urandom);
            end
        end
    end

    // Monitor: check results, then predict for an accepted transaction
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome pred;
        if (!i_rst_n) begin
            took_cmd <= 1'b0;
            sched_queued = '0;
            sched_pending = '0;
            sched_scan = '0;
            sched_running = 1'b0;
            sched_run_idx = '0;
        end else begin
            if (o_result_valid) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result status=%0d dv=%0b task=%0d idle=%0b",
                             $time, o_task_status, o_dispatch_valid, o_dispatched_task,
                             o_idle_run);
                    error_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_task_status !== want.status) begin
                        $display("%0t: task_status expected %0d actual %0d",
                                 $time, want.status, o_task_status);
                        error_count++;
                    end
                    if (o_dispatch_valid !== want.dispatch_valid) begin
                        $display("%0t: dispatch_valid expected %0b actual %0b",
                                 $time, want.dispatch_valid, o_dispatch_valid);
                        error_count++;
                    end
                    if (o_dispatched_task !== want.dispatched) begin
                        $display("%0t: dispatched_task expected %0d actual %0d",
                                 $time, want.dispatched, o_dispatched_task);
                        error_count++;
                    end
                    if (o_idle_run !== want.idle_run) begin
                        $display("%0t: idle_run expected %0b actual %0b",
                                 $time, want.idle_run, o_idle_run);
                        error_count++;
                    end
                end
            end
            took_cmd <= start && !busy;
            if (start && !busy) begin
                schedule_step(i_opcode, i_task_index, pred);
                expected_outcomes.push_back(pred);
                cmds_taken++;
            end
        end
    end

    // Queue one command transaction
    task automatic add_cmd(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] idx,
                           input int unsigned gap_pct);
        t_cmd c;
        c.op = op;
        c.idx = idx;
        c.gap_pct = gap_pct;
        cmd_queue.push_back(c);
    endtask

    // Queue a random transaction: mostly queue, query and advance, a few unused
    task automatic add_random_cmd(input int unsigned gap_pct, input t_bool narrow);
        int unsigned r;
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] idx;
        r = $urandom_range(99);
        if (r < 42) begin
            op = OP_QUEUE;
        end else if (r < 70) begin
            op = OP_QUERY;
        end else if (r < 95) begin
            op = OP_ADVANCE;
        end else begin
            op = OP_UNUSED;
        end
        // Narrow runs crowd eight tasks (0-3 and 12-15) so queue/pending/running overlap
        if (narrow) begin
            idx = ($urandom_range(1) == 0) ? TASK_W'($urandom_range(3))
                                           : TASK_W'(12 + $urandom_range(3));
        end else begin
            idx = TASK_W'($urandom);
        end
        add_cmd(op, idx, gap_pct);
    endtask

    // Stimulus and end of run
    initial begin
        int unsigned phase_gap[4];
        int unsigned total_cmds;
        phase_gap[0] = 0;
        phase_gap[1] = 67;
        phase_gap[2] = 0;
        phase_gap[3] = 26;

        // Directed: idle advance, snapshot, merge ahead of pending, precedence
        add_cmd(OP_ADVANCE, 4'd0, 0);
        add_cmd(OP_QUERY, 4'd0, 0);
        add_cmd(OP_QUEUE, 4'd0, 0);
        add_cmd(OP_QUEUE, 4'd15, 0);
        add_cmd(OP_QUERY, 4'd0, 0);
        add_cmd(OP_QUERY, 4'd15, 0);
        add_cmd(OP_ADVANCE, 4'd9, 0);
        add_cmd(OP_QUERY, 4'd0, 0);
        add_cmd(OP_QUEUE, 4'd0, 0);
        add_cmd(OP_QUERY, 4'd0, 0);
        add_cmd(OP_ADVANCE, 4'd15, 0);
        add_cmd(OP_QUERY, 4'd15, 0);
        add_cmd(OP_QUEUE, 4'd15, 0);
        add_cmd(OP_QUERY, 4'd15, 0);
        add_cmd(OP_ADVANCE, 4'd0, 0);
        add_cmd(OP_QUERY, 4'd15, 0);
        add_cmd(OP_ADVANCE, 4'd0, 0);
        add_cmd(OP_ADVANCE, 4'd0, 0);
        add_cmd(OP_QUERY, 4'd15, 0);
        add_cmd(OP_UNUSED, 4'd15, 0);
        add_cmd(OP_UNUSED, 4'd0, 0);
        add_cmd(OP_QUERY, 4'd7, 0);

        // Random: four idling phases, alternating wide and narrow task ranges
        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < 465; n++) begin
                add_random_cmd(phase_gap[p], t_bool'((n / 60) % 2));
            end
        end
        total_cmds = cmd_queue.size();

        // Hold reset, then release it at a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: all accepted, all results back, then a short tail
        while (cmds_taken < total_cmds || expected_outcomes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("PASS priority_task_dispatcher");
        end else begin
            $display("FAIL priority_task_dispatcher");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL priority_task_dispatcher");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ptd_pkg.sv
hw/rtl/ptd_ctrl.sv
hw/rtl/ptd_datapath.sv
hw/rtl/priority_task_dispatcher.sv
hw/rtl/ptd_checker.sv
verif/priority_task_dispatcher_tb.sv
